FILE: hw/rtl/positional_list_store_assert.svh
// ----------------------------------------------------------------------------
// positional_list_store_assert.svh
// Assertion macros used by the checker file of the positional list store.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Check on every clock edge outside of reset.
`define PLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Request and response types and codes of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int ACTION_BITS = 2;
    localparam int POS_BITS    = 5;
    localparam int WORD_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_POS  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ACTION_BITS-1:0]      action;
        logic [POS_BITS-1:0]         position;
        logic signed [WORD_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]      status;
        logic signed [WORD_BITS-1:0] read_value;
        logic [COUNT_BITS-1:0]       count;
    } rsp_t;

endpackage

FILE: hw/rtl/pls_entry_row.sv
// ----------------------------------------------------------------------------
// pls_entry_row
// Row of entry registers with the entry count. Applies one request per
// enabled cycle: shifts the row in parallel and forms the response.
// ----------------------------------------------------------------------------
module pls_entry_row #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  pls_pkg::req_t req,
    output pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [DATA_BITS-1:0] entry_reg  [DEPTH];
    logic [DATA_BITS-1:0] entry_next [DEPTH];
    logic [DATA_BITS-1:0] up_src     [DEPTH];
    logic [DATA_BITS-1:0] down_src   [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic [63:0]          wide_in;
    logic [63:0]          wide_out;
    logic [DATA_BITS-1:0] wr_word;
    logic [DATA_BITS-1:0] rd_word;
    logic                 pos_hit;
    logic                 ins_ok;
    logic                 full_err;
    logic                 del_ok;
    logic                 rd_ok;

    // Neighbor taps for the up and down shifts; the row ends keep their own word.
    for (genvar k = 0; k < DEPTH; k++) begin : g_taps
        if (k == 0) begin : g_first
            assign up_src[k] = entry_reg[k];
        end else begin : g_up
            assign up_src[k] = entry_reg[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign down_src[k] = entry_reg[k];
        end else begin : g_down
            assign down_src[k] = entry_reg[k+1];
        end
    end

    always_comb
    begin
        pos_x    = XW'(req.position);
        cnt_x    = XW'(count_reg);
        wide_in  = {32'd0, req.value};
        wr_word  = wide_in[DATA_BITS-1:0];
        pos_hit  = pos_x < cnt_x;
        ins_ok   = (req.action == ACT_INSERT) && (pos_x <= cnt_x) && (cnt_x != XW'(DEPTH));
        full_err = (req.action == ACT_INSERT) && (pos_x <= cnt_x) && (cnt_x == XW'(DEPTH));
        del_ok   = (req.action == ACT_DELETE) && pos_hit;
        rd_ok    = (req.action == ACT_READ) && pos_hit;

        rd_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (pos_x == XW'(k)) begin
                rd_word = entry_reg[k];
            end
        end

        for (int k = 0; k < DEPTH; k++) begin
            entry_next[k] = entry_reg[k];
            if (ins_ok) begin
                if (XW'(k) == pos_x) begin
                    entry_next[k] = wr_word;
                end else if (XW'(k) > pos_x) begin
                    entry_next[k] = up_src[k];
                end
            end else if (del_ok) begin
                if (XW'(k) >= pos_x) begin
                    entry_next[k] = down_src[k];
                end
            end
        end

        if (ins_ok) begin
            count_next = count_reg + CW'(1);
        end else if (del_ok) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end

        wide_out = (del_ok || rd_ok) ? 64'(rd_word) : 64'd0;

        if (ins_ok || del_ok || rd_ok) begin
            rsp.status = ST_OK;
        end else if (full_err) begin
            rsp.status = ST_FULL;
        end else begin
            rsp.status = ST_POS;
        end
        rsp.read_value = wide_out[WORD_BITS-1:0];
        rsp.count      = COUNT_BITS'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: hw/rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH words addressed by position, with insert,
// delete and read requests. Every request returns one response carrying a
// status, the removed or read word and the entry count after the request.
// One request is taken per cycle while req_stall is low; a request passes
// through the request register, then the response register, and the
// whole entry row shifts between those two registers, so back-to-back
// requests see each other's effect. A stalled response holds the request
// register and then the request port; no reset sweep is needed, the store
// is usable as soon as reset is released.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    logic req_vld_reg;
    logic req_vld_next;
    req_t req_item_reg;
    logic rsp_vld_reg;
    logic rsp_vld_next;
    rsp_t rsp_item_reg;
    rsp_t row_rsp;
    logic adv;
    logic req_take;

    // Advance the held request when the response register is free or draining.
    assign adv       = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !adv;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        if (req_take) begin
            req_vld_next = 1'b1;
        end else if (adv) begin
            req_vld_next = 1'b0;
        end else begin
            req_vld_next = req_vld_reg;
        end

        if (adv) begin
            rsp_vld_next = 1'b1;
        end else if (!rsp_stall) begin
            rsp_vld_next = 1'b0;
        end else begin
            rsp_vld_next = rsp_vld_reg;
        end
    end

    pls_entry_row #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .req   (req_item_reg),
        .rsp   (row_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end else begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take) begin
            req_item_reg <= req;
        end
        if (adv) begin
            rsp_item_reg <= row_rsp;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_item_reg;

endmodule

FILE: hw/rtl/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks of the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_store_assert.svh"

module pls_checker #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input pls_pkg::rsp_t rsp
);
    import pls_pkg::*;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

    `PLS_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_n |-> !rsp_valid, "response valid during reset")
    `PLS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")
    `PLS_ASSERT(a_count_bound, rsp_valid |-> (DEPTH > 31) || (rsp.count <= FULL_COUNT), "count above depth")
    `PLS_ASSERT(a_full_count, rsp_valid && rsp.status == ST_FULL |-> rsp.count == FULL_COUNT, "full error while not full")
    `PLS_ASSERT(a_err_zero, rsp_valid && rsp.status != ST_OK |-> rsp.read_value == 0, "error response carries data")

endmodule

bind positional_list_store pls_checker #(
    .DEPTH (DEPTH)
) u_pls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
